// ===== rtl/core/spi_transfer_ack_sequencer_core_assert.svh =====
// assertion macros shared by the sequencer core
`ifndef SPI_TRANSFER_ACK_SEQUENCER_CORE_ASSERT_SVH
`define SPI_TRANSFER_ACK_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define STAS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define STAS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/stas_pkg.sv =====
package stas_pkg;

    localparam int DEFAULT_BUFFER_DEPTH = 256;

    // position counter width, wide enough for length plus full try limit
    localparam int POS_W = 17;

    typedef enum logic [2:0] {
        FUNC_LOAD  = 3'd0,
        FUNC_READ  = 3'd1,
        FUNC_START = 3'd2,
        FUNC_XCHG  = 3'd3,
        FUNC_ABORT = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        CFG_BUFFER_LENGTH     = 3'd0,
        CFG_RECEIVE_OFFSET    = 3'd1,
        CFG_RECEIVE_COUNT     = 3'd2,
        CFG_OPTIONS           = 3'd3,
        CFG_ACK_TRY_LIMIT     = 3'd4,
        CFG_ACK_MATCH_BYTE    = 3'd5,
        CFG_ACK_REQUEST_BYTE  = 3'd6,
        CFG_TRANSMIT_CONSTANT = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        ACK_NONE    = 2'd0,
        ACK_EQUAL   = 2'd1,
        ACK_DIFF    = 2'd2,
        ACK_INVALID = 2'd3
    } ack_mode_t;

    // option bits
    localparam int OPT_CONST_BIT    = 2;
    localparam int OPT_DESELECT_BIT = 3;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       chip_select;
        logic       done_res;
        logic       ack_ok;
        logic [7:0] ack_value;
        logic [7:0] read_data;
        logic       busy_res;
        logic       start_refused;
    } res_t;

endpackage

// ===== rtl/core/stas_ram.sv =====
module stas_ram
    import stas_pkg::*;
#(
    parameter int DEPTH = DEFAULT_BUFFER_DEPTH,
    parameter int AW    = 8
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [0:DEPTH-1];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/spi_transfer_ack_sequencer_core.sv =====
// spi master transfer sequencer. one host item is taken per clock while the output does not
// stall, and each gives exactly one result: the item passes the read stage, where the data
// buffer ram is read synchronously, and then the output register. the sustained rate is one
// item per cycle while the output does not stall, set by the single write and single read
// port of the buffer ram; a load or a received-byte store writes at the accept edge, so the
// next item already reads the new value and no forwarding is needed. the buffer has no
// reset and no clearing pass: a byte that was never loaded reads as anything. configuration
// writes are taken in any cycle and must only be made while no item is in flight.
`include "spi_transfer_ack_sequencer_core_assert.svh"

module spi_transfer_ack_sequencer_core
    import stas_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // index[7:0], data_byte[15:8], received_byte[23:16]
    input  logic [2:0]  s_axis_tuser,   // func[2:0]
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tx_valid[0], tx_byte[8:1], chip_select[9], done_res[10], ack_ok[11],
    // ack_value[19:12], read_data[27:20], busy_res[28], start_refused[29], zero[31:30]
    output logic [31:0] m_axis_tdata,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam logic [POS_W-1:0] DEPTH_P = POS_W'(BUFFER_DEPTH);

    // configuration registers
    logic [8:0]  buffer_length_reg;
    logic [8:0]  receive_offset_reg;
    logic [8:0]  receive_count_reg;
    logic [3:0]  options_reg;
    logic [15:0] ack_try_limit_reg;
    logic [7:0]  ack_match_byte_reg;
    logic [7:0]  ack_request_byte_reg;
    logic [7:0]  transmit_constant_reg;

    // sequencer state
    logic             active_reg, active_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             sel_reg, sel_next;
    ack_mode_t        eam_reg, eam_next;
    logic [8:0]       window_reg, window_next;

    // read stage and output register
    logic s1_valid_reg, s1_valid_next;
    res_t s1_res_reg, s1_res_next;
    logic s1_tx_mem_reg, s1_tx_mem_next;
    logic s1_rd_mem_reg, s1_rd_mem_next;
    logic out_valid_reg, out_valid_next;
    res_t out_res_reg, out_res_next;

    // buffer ram ports
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    logic accept;
    logic advance;
    func_t func;
    logic [7:0] in_index;
    logic [7:0] in_data;
    logic [7:0] in_rx;
    logic [8:0] len;
    logic [POS_W-1:0] len_p;
    res_t merged;

    assign func     = func_t'(s_axis_tuser);
    assign in_index = s_axis_tdata[7:0];
    assign in_data  = s_axis_tdata[15:8];
    assign in_rx    = s_axis_tdata[23:16];

    // item moves from read stage to output register when the latter is free or drains
    assign advance       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // length clipped to the buffer depth, taken live
    always_comb
    begin
        if ({8'd0, buffer_length_reg} < DEPTH_P)
        begin
            len = buffer_length_reg;
        end
        else
        begin
            len = DEPTH_P[8:0];
        end
    end
    assign len_p = {8'd0, len};

    // configuration write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_length_reg     <= '0;
            receive_offset_reg    <= '0;
            receive_count_reg     <= '0;
            options_reg           <= '0;
            ack_try_limit_reg     <= '0;
            ack_match_byte_reg    <= '0;
            ack_request_byte_reg  <= '0;
            transmit_constant_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_BUFFER_LENGTH:     buffer_length_reg     <= cfg_data[8:0];
                CFG_RECEIVE_OFFSET:    receive_offset_reg    <= cfg_data[8:0];
                CFG_RECEIVE_COUNT:     receive_count_reg     <= cfg_data[8:0];
                CFG_OPTIONS:           options_reg           <= cfg_data[3:0];
                CFG_ACK_TRY_LIMIT:     ack_try_limit_reg     <= cfg_data;
                CFG_ACK_MATCH_BYTE:    ack_match_byte_reg    <= cfg_data[7:0];
                CFG_ACK_REQUEST_BYTE:  ack_request_byte_reg  <= cfg_data[7:0];
                CFG_TRANSMIT_CONSTANT: transmit_constant_reg <= cfg_data[7:0];
                default:               ;
            endcase
        end
    end

    // item decode: state update, buffer access and result fields without ram data
    always_comb
    begin
        logic [POS_W-1:0] idx_p;
        logic             idx_ok;
        logic [POS_W-1:0] new_pos;
        logic [POS_W-1:0] tries;
        logic [9:0]       win_end;
        logic [9:0]       rx_end;
        ack_mode_t        start_mode;
        logic             do_finish;
        logic             fin_ok;
        logic [7:0]       fin_val;
        logic             complete;
        logic             ok;

        idx_p      = {9'd0, in_index};
        idx_ok     = idx_p < DEPTH_P;
        new_pos    = pos_reg + POS_W'(1);
        tries      = new_pos - len_p;
        win_end    = {1'b0, receive_offset_reg} + {1'b0, receive_count_reg};
        rx_end     = {1'b0, receive_offset_reg} + {1'b0, window_reg};
        start_mode = (ack_try_limit_reg != 16'd0) ? ack_mode_t'(options_reg[1:0]) : ACK_NONE;
        do_finish  = 1'b0;
        fin_ok     = 1'b0;
        fin_val    = 8'd0;
        complete   = 1'b0;
        ok         = 1'b0;

        s1_res_next    = '0;
        s1_tx_mem_next = 1'b0;
        s1_rd_mem_next = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = pos_reg[AW-1:0];
        mem_wdata      = in_rx;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        active_next    = active_reg;
        pos_next       = pos_reg;
        sel_next       = sel_reg;
        eam_next       = eam_reg;
        window_next    = window_reg;

        if (accept)
        begin
            unique case (func)
                FUNC_LOAD:
                begin
                    mem_we    = idx_ok;
                    mem_waddr = idx_p[AW-1:0];
                    mem_wdata = in_data;
                end
                FUNC_READ:
                begin
                    mem_re         = idx_ok;
                    mem_raddr      = idx_p[AW-1:0];
                    s1_rd_mem_next = idx_ok;
                end
                FUNC_START:
                begin
                    if (active_reg)
                    begin
                        s1_res_next.start_refused = 1'b1;
                    end
                    else
                    begin
                        eam_next = start_mode;
                        if (len == 9'd0 && start_mode == ACK_NONE)
                        begin
                            do_finish = 1'b1;
                        end
                        else
                        begin
                            if (receive_offset_reg < len && win_end > {1'b0, len})
                            begin
                                window_next = len - receive_offset_reg;
                            end
                            else
                            begin
                                window_next = receive_count_reg;
                            end
                            sel_next             = 1'b1;
                            pos_next             = '0;
                            active_next          = 1'b1;
                            s1_res_next.tx_valid = 1'b1;
                            if (len == 9'd0)
                            begin
                                s1_res_next.tx_byte = ack_request_byte_reg;
                            end
                            else if (options_reg[OPT_CONST_BIT])
                            begin
                                s1_res_next.tx_byte = transmit_constant_reg;
                            end
                            else
                            begin
                                mem_re         = 1'b1;
                                s1_tx_mem_next = 1'b1;
                            end
                        end
                    end
                end
                FUNC_XCHG:
                begin
                    if (active_reg)
                    begin
                        // store the reply if inside the receive window and the length
                        if (pos_reg >= {8'd0, receive_offset_reg} &&
                            pos_reg < {7'd0, rx_end} &&
                            pos_reg < len_p && pos_reg < DEPTH_P)
                        begin
                            mem_we = 1'b1;
                        end
                        pos_next = new_pos;
                        if (new_pos < len_p)
                        begin
                            s1_res_next.tx_valid = 1'b1;
                            if (options_reg[OPT_CONST_BIT])
                            begin
                                s1_res_next.tx_byte = transmit_constant_reg;
                            end
                            else
                            begin
                                mem_re         = 1'b1;
                                mem_raddr      = new_pos[AW-1:0];
                                s1_tx_mem_next = 1'b1;
                            end
                        end
                        else if (tries == '0)
                        begin
                            // data phase over: poll or finish
                            if (eam_reg != ACK_NONE)
                            begin
                                s1_res_next.tx_valid = 1'b1;
                                s1_res_next.tx_byte  = ack_request_byte_reg;
                            end
                            else
                            begin
                                do_finish = 1'b1;
                            end
                        end
                        else if (tries <= {1'b0, ack_try_limit_reg})
                        begin
                            case (eam_reg)
                                ACK_EQUAL:
                                begin
                                    complete = (in_rx == ack_match_byte_reg);
                                    ok       = complete;
                                end
                                ACK_DIFF:
                                begin
                                    complete = (in_rx != ack_match_byte_reg);
                                    ok       = complete;
                                end
                                default:
                                begin
                                    complete = 1'b1;
                                end
                            endcase
                            if (tries == {1'b0, ack_try_limit_reg})
                            begin
                                complete = 1'b1;
                            end
                            if (complete)
                            begin
                                do_finish = 1'b1;
                                fin_ok    = ok;
                                fin_val   = in_rx;
                            end
                            else
                            begin
                                s1_res_next.tx_valid = 1'b1;
                                s1_res_next.tx_byte  = ack_request_byte_reg;
                            end
                        end
                        else
                        begin
                            // limit lowered below the tries already made
                            do_finish = 1'b1;
                            fin_val   = in_rx;
                        end
                    end
                end
                FUNC_ABORT:
                begin
                    active_next = 1'b0;
                end
                default:
                begin
                end
            endcase

            if (do_finish)
            begin
                if (options_reg[OPT_DESELECT_BIT])
                begin
                    sel_next = 1'b0;
                end
                active_next           = 1'b0;
                eam_next              = ACK_NONE;
                s1_res_next.done_res  = 1'b1;
                s1_res_next.ack_ok    = fin_ok;
                s1_res_next.ack_value = fin_val;
            end
        end

        s1_res_next.chip_select = sel_next;
        s1_res_next.busy_res    = active_next;
    end

    stas_ram #(
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // fold the ram data into the result as it leaves the read stage
    always_comb
    begin
        merged = s1_res_reg;
        if (s1_tx_mem_reg)
        begin
            merged.tx_byte = mem_rdata;
        end
        if (s1_rd_mem_reg)
        begin
            merged.read_data = mem_rdata;
        end
    end

    always_comb
    begin
        s1_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
        out_res_next   = advance ? merged : out_res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            pos_reg       <= '0;
            sel_reg       <= 1'b0;
            eam_reg       <= ACK_NONE;
            window_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            pos_reg       <= pos_next;
            sel_reg       <= sel_next;
            eam_reg       <= eam_next;
            window_reg    <= window_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg    <= s1_res_next;
            s1_tx_mem_reg <= s1_tx_mem_next;
            s1_rd_mem_reg <= s1_rd_mem_next;
        end
        out_res_reg <= out_res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00,
                            out_res_reg.start_refused,
                            out_res_reg.busy_res,
                            out_res_reg.read_data,
                            out_res_reg.ack_value,
                            out_res_reg.ack_ok,
                            out_res_reg.done_res,
                            out_res_reg.chip_select,
                            out_res_reg.tx_byte,
                            out_res_reg.tx_valid};

    // a full pipe with a stalled output must refuse new items
    `STAS_ASSERT_IMPL(a_stall_blocks_input, s1_valid_reg && out_valid_reg && !m_axis_tready, !s_axis_tready, "input taken while pipe is stalled")
    // an accepted item always occupies the read stage next cycle
    `STAS_ASSERT_NEXT(a_accept_fills_stage, accept, s1_valid_reg, "accepted item lost before read stage")
    // a running transfer always has the slave selected
    `STAS_ASSERT_IMPL(a_active_selects, active_reg, sel_reg, "transfer active with slave deselected")
    // a finishing result never reports the transfer as still running
    `STAS_ASSERT_IMPL(a_done_not_busy, out_valid_reg && out_res_reg.done_res, !out_res_reg.busy_res, "done result reports busy")

endmodule
